FILE: hw/rtl/lr_pkg.sv
// Shared constants and types of the line rasterizer.
// Depends on nothing; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package lr_pkg;

  // Fixed field widths of the stream payloads.
  localparam int COORD_W   = 6;
  localparam int COLOR_W   = 32;

  // Input tdata layout: start_x, start_y, end_x, end_y, line_color.
  localparam int IN_SX_LSB    = 0;
  localparam int IN_SY_LSB    = COORD_W;
  localparam int IN_EX_LSB    = 2 * COORD_W;
  localparam int IN_EY_LSB    = 3 * COORD_W;
  localparam int IN_COLOR_LSB = 4 * COORD_W;
  localparam int IN_DATA_W    = 4 * COORD_W + COLOR_W;

  // Output tdata layout: pixel_x, pixel_y, pixel_color, zero padding.
  localparam int OUT_USED_W = 2 * COORD_W + COLOR_W;
  localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - OUT_USED_W;

  // Back-end sequencer states.
  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } bk_state_t;

  // Status of the segment queue as seen by its neighbours.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

FILE: hw/rtl/lr_front.sv
// Front end of the line rasterizer: accepts segments and classifies them.
// Works out the major axis, the start of the span and the step of the minor axis.
// Depends on lr_pkg.
`timescale 1ns / 1ps

module lr_front #(
  parameter int CB = 6
) (
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [lr_pkg::IN_DATA_W-1:0]  in_tdata,
  input  lr_pkg::q_status_t             q_status,
  output logic                          push,
  output logic [CB-1:0]                 seg_lo,
  output logic [CB-1:0]                 seg_minor0,
  output logic [CB-1:0]                 seg_dmaj,
  output logic signed [CB:0]            seg_dmin,
  output logic                          seg_ymaj,
  output logic [lr_pkg::COLOR_W-1:0]    seg_color
);

  logic [CB-1:0]        sx, sy, ex, ey;
  logic signed [CB:0]   dx, dy, ndx, ndy;
  logic [CB-1:0]        adx, ady;
  logic signed [CB:0]   dmaj_s, dmin_s;
  logic                 rev;

  // Only the low coordinate bits take part.
  assign sx = in_tdata[lr_pkg::IN_SX_LSB +: CB];
  assign sy = in_tdata[lr_pkg::IN_SY_LSB +: CB];
  assign ex = in_tdata[lr_pkg::IN_EX_LSB +: CB];
  assign ey = in_tdata[lr_pkg::IN_EY_LSB +: CB];
  assign seg_color = in_tdata[lr_pkg::IN_COLOR_LSB +: lr_pkg::COLOR_W];

  // Signed deltas and their magnitudes.
  assign dx  = $signed({1'b0, ex}) - $signed({1'b0, sx});
  assign dy  = $signed({1'b0, ey}) - $signed({1'b0, sy});
  assign ndx = -dx;
  assign ndy = -dy;
  assign adx = dx[CB] ? ndx[CB-1:0] : dx[CB-1:0];
  assign ady = dy[CB] ? ndy[CB-1:0] : dy[CB-1:0];

  // Axis choice: x is major only when dx is nonzero and the slope is at most one.
  assign seg_ymaj = (dx == '0) || (ady > adx);

  assign dmaj_s   = seg_ymaj ? dy : dx;
  assign dmin_s   = seg_ymaj ? dx : dy;
  assign rev      = dmaj_s[CB];
  assign seg_dmaj = seg_ymaj ? ady : adx;
  assign seg_dmin = rev ? -dmin_s : dmin_s;

  // A reversed segment starts at its end point, where the remainder is zero.
  always_comb begin
    if (seg_ymaj) begin
      seg_lo     = rev ? ey : sy;
      seg_minor0 = rev ? ex : sx;
    end else begin
      seg_lo     = rev ? ex : sx;
      seg_minor0 = rev ? ey : sy;
    end
  end

  // Segments with an empty span are taken and dropped here.
  assign in_tready = !q_status.full;
  assign push      = in_tvalid && !q_status.full && (seg_dmaj != '0);

endmodule

FILE: hw/rtl/lr_queue.sv
// Short register queue that holds classified segments between front and back end.
// Depends on lr_pkg for the status type.
`timescale 1ns / 1ps

module lr_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [W-1:0]      din,
  input  logic              pop,
  output logic [W-1:0]      dout,
  output lr_pkg::q_status_t status
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign status.full  = (count_r == CW'(DEPTH));
  assign status.empty = (count_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign dout         = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

FILE: hw/rtl/lr_back.sv
// Rasterizer back end: steps a segment a pixel per cycle while its output slot is free.
// Keeps the minor coordinate and remainder incrementally and drives the output register.
// Depends on lr_pkg.
`timescale 1ns / 1ps

module lr_back #(
  parameter int CB = 6
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  output logic                        pop,
  input  logic [CB-1:0]               seg_lo,
  input  logic [CB-1:0]               seg_minor0,
  input  logic [CB-1:0]               seg_dmaj,
  input  logic signed [CB:0]          seg_dmin,
  input  logic                        seg_ymaj,
  input  logic [lr_pkg::COLOR_W-1:0]  seg_color,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [lr_pkg::COORD_W-1:0]  pixel_x,
  output logic [lr_pkg::COORD_W-1:0]  pixel_y,
  output logic [lr_pkg::COLOR_W-1:0]  pixel_color,
  output logic                        last_pixel
);

  localparam int OW = lr_pkg::COORD_W;

  lr_pkg::bk_state_t state_r, state_nxt;

  // Segment being drawn.
  logic [CB-1:0]               major_r, major_nxt;
  logic [CB-1:0]               minor_r, minor_nxt;
  logic [CB-1:0]               err_r, err_nxt;
  logic [CB-1:0]               rem_r, rem_nxt;
  logic [CB-1:0]               dmaj_r, dmaj_nxt;
  logic signed [CB:0]          dmin_r, dmin_nxt;
  logic                        ymaj_r, ymaj_nxt;
  logic [lr_pkg::COLOR_W-1:0]  color_r, color_nxt;

  // Output register.
  logic                        ovalid_r, ovalid_nxt;
  logic [OW-1:0]               ox_r, ox_nxt;
  logic [OW-1:0]               oy_r, oy_nxt;
  logic [lr_pkg::COLOR_W-1:0]  ocolor_r, ocolor_nxt;
  logic                        olast_r, olast_nxt;

  logic                        slot_free, emit;
  logic signed [CB+1:0]        sum, dmaj_ext, sum_lo, sum_hi;

  assign slot_free = !ovalid_r || out_ready;

  // Remainder step: one add, one correction in either direction.
  assign dmaj_ext = $signed({2'b00, dmaj_r});
  assign sum      = $signed({2'b00, err_r}) + $signed({dmin_r[CB], dmin_r});
  assign sum_hi   = sum - dmaj_ext;
  assign sum_lo   = sum + dmaj_ext;

  // Sequencer: load a segment from the queue, then emit its pixels.
  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    emit      = 1'b0;
    major_nxt = major_r;
    minor_nxt = minor_r;
    err_nxt   = err_r;
    rem_nxt   = rem_r;
    dmaj_nxt  = dmaj_r;
    dmin_nxt  = dmin_r;
    ymaj_nxt  = ymaj_r;
    color_nxt = color_r;
    unique case (state_r)
      lr_pkg::BK_IDLE: begin
        if (q_valid) begin
          pop       = 1'b1;
          major_nxt = seg_lo;
          minor_nxt = seg_minor0;
          err_nxt   = '0;
          rem_nxt   = seg_dmaj;
          dmaj_nxt  = seg_dmaj;
          dmin_nxt  = seg_dmin;
          ymaj_nxt  = seg_ymaj;
          color_nxt = seg_color;
          state_nxt = lr_pkg::BK_RUN;
        end
      end
      lr_pkg::BK_RUN: begin
        if (slot_free) begin
          emit      = 1'b1;
          major_nxt = major_r + 1'b1;
          rem_nxt   = rem_r - 1'b1;
          priority if (sum >= dmaj_ext) begin
            err_nxt   = sum_hi[CB-1:0];
            minor_nxt = minor_r + 1'b1;
          end else if (sum < 0) begin
            err_nxt   = sum_lo[CB-1:0];
            minor_nxt = minor_r - 1'b1;
          end else begin
            err_nxt   = sum[CB-1:0];
          end
          if (rem_r == CB'(1)) begin
            state_nxt = lr_pkg::BK_IDLE;
          end
        end
      end
      default: begin
        state_nxt = lr_pkg::BK_IDLE;
      end
    endcase
  end

  // Output register: loads on emit, empties when taken.
  always_comb begin
    ovalid_nxt = ovalid_r;
    ox_nxt     = ox_r;
    oy_nxt     = oy_r;
    ocolor_nxt = ocolor_r;
    olast_nxt  = olast_r;
    if (emit) begin
      ovalid_nxt = 1'b1;
      ox_nxt     = OW'(ymaj_r ? minor_r : major_r);
      oy_nxt     = OW'(ymaj_r ? major_r : minor_r);
      ocolor_nxt = color_r;
      olast_nxt  = (rem_r == CB'(1));
    end else if (out_ready) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= lr_pkg::BK_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    major_r  <= major_nxt;
    minor_r  <= minor_nxt;
    err_r    <= err_nxt;
    rem_r    <= rem_nxt;
    dmaj_r   <= dmaj_nxt;
    dmin_r   <= dmin_nxt;
    ymaj_r   <= ymaj_nxt;
    color_r  <= color_nxt;
    ox_r     <= ox_nxt;
    oy_r     <= oy_nxt;
    ocolor_r <= ocolor_nxt;
    olast_r  <= olast_nxt;
  end

  assign out_valid   = ovalid_r;
  assign pixel_x     = ox_r;
  assign pixel_y     = oy_r;
  assign pixel_color = ocolor_r;
  assign last_pixel  = olast_r;

endmodule

FILE: hw/rtl/line_rasterizer.sv
// Line rasterizer: a segment is taken whenever the queue has room; its first pixel
// passes through the queue, the back end's segment registers and then the output register.
// The back end emits one pixel per cycle while the output register has room, and loads
// each segment from the queue in its idle state before it steps that segment's pixels.
// Segments with an empty span are taken and produce nothing.
// Synchronous active-low reset empties the queue and the output register; no clearing pass.
`timescale 1ns / 1ps

module line_rasterizer #(
  parameter int COORD_BITS  = 6,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // start_x[5:0], start_y[11:6], end_x[17:12], end_y[23:18], line_color[55:24]
  input  logic [lr_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // pixel_x[5:0], pixel_y[11:6], pixel_color[43:12], zero padding[47:44]
  output logic [lr_pkg::OUT_DATA_W-1:0]  out_tdata,
  // last_pixel
  output logic                           out_tlast
);

  localparam int CB    = COORD_BITS;
  localparam int SEG_W = lr_pkg::COLOR_W + 1 + (CB + 1) + 3 * CB;

  lr_pkg::q_status_t            q_status;
  logic                         push, pop;
  logic [CB-1:0]                f_lo, f_minor0, f_dmaj;
  logic signed [CB:0]           f_dmin;
  logic                         f_ymaj;
  logic [lr_pkg::COLOR_W-1:0]   f_color;
  logic [CB-1:0]                b_lo, b_minor0, b_dmaj;
  logic signed [CB:0]           b_dmin;
  logic                         b_ymaj;
  logic [lr_pkg::COLOR_W-1:0]   b_color;
  logic [SEG_W-1:0]             q_din, q_dout;
  logic [lr_pkg::COORD_W-1:0]   pixel_x, pixel_y;
  logic [lr_pkg::COLOR_W-1:0]   pixel_color;

  lr_front #(
    .CB (CB)
  ) u_front (
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .q_status   (q_status),
    .push       (push),
    .seg_lo     (f_lo),
    .seg_minor0 (f_minor0),
    .seg_dmaj   (f_dmaj),
    .seg_dmin   (f_dmin),
    .seg_ymaj   (f_ymaj),
    .seg_color  (f_color)
  );

  // Segment record packed for the queue.
  assign q_din = {f_color, f_ymaj, f_dmin, f_dmaj, f_minor0, f_lo};

  lr_queue #(
    .W     (SEG_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .din    (q_din),
    .pop    (pop),
    .dout   (q_dout),
    .status (q_status)
  );

  assign {b_color, b_ymaj, b_dmin, b_dmaj, b_minor0, b_lo} = q_dout;

  lr_back #(
    .CB (CB)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (!q_status.empty),
    .pop         (pop),
    .seg_lo      (b_lo),
    .seg_minor0  (b_minor0),
    .seg_dmaj    (b_dmaj),
    .seg_dmin    (b_dmin),
    .seg_ymaj    (b_ymaj),
    .seg_color   (b_color),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_color (pixel_color),
    .last_pixel  (out_tlast)
  );

  assign out_tdata = {{lr_pkg::OUT_PAD_W{1'b0}}, pixel_color, pixel_y, pixel_x};

endmodule

FILE: hw/rtl/lr_checker.sv
// Port-level checker for the line rasterizer, attached to the top level by bind.
// Depends on lr_pkg for the payload widths.
`timescale 1ns / 1ps

module lr_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [lr_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                          out_tlast
);

  localparam int CLSB = 2 * lr_pkg::COORD_W;
  localparam int CMSB = CLSB + lr_pkg::COLOR_W - 1;

  // A pending pixel stays offered.
  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("pixel transaction withdrawn before it was taken");

  // A stalled pixel keeps its payload.
  a_out_stable : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled pixel payload changed");

  // Within a segment the next pixel follows at once and carries the same colour.
  a_seg_cont : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      out_tvalid && (out_tdata[CMSB:CLSB] == $past(out_tdata[CMSB:CLSB])))
    else $error("segment broken off or colour changed mid-segment");

  // Padding bits above the colour are always zero.
  a_pad_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[lr_pkg::OUT_DATA_W-1:lr_pkg::OUT_USED_W] == '0))
    else $error("output padding bits are not zero");

endmodule

bind line_rasterizer lr_checker u_lr_checker (.*);
